/* rtl/scbr_pkg.sv */
package scbr_pkg;

   typedef enum logic [2:0] {
      ST_HIT  = 3'd0,
      ST_NEW  = 3'd1,
      ST_FULL = 3'd2,
      ST_REL  = 3'd3,
      ST_DONE = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      MODE_REQ = 2'd0,
      MODE_EOF = 2'd1,
      MODE_RAL = 2'd2,
      MODE_NOP = 2'd3
   } mode_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_REQ_RD,
      S_REQ_CHK,
      S_REQ_SHIFT,
      S_REQ_NEW,
      S_EOF_RD,
      S_EOF_CHK,
      S_EOF_ACT,
      S_EOF_KEEP,
      S_RAL,
      S_DONE
   } state_type;

   localparam logic REG_MIN_ALLOC = 1'b0;
   localparam logic REG_MAX_IDLE  = 1'b1;
   localparam logic [31:0] MIN_ALLOC_RESET = 32'd65536;
   localparam logic [7:0]  MAX_IDLE_RESET  = 8'd8;

endpackage

/* rtl/size_class_buffer_recycler.sv */
// Buffer pool manager for up to SLOTS buffers.
// Input channel: req_mode / req_request_size are taken when start is high
// and busy is low. Mode 0 requests a buffer, 1 ends a frame, 2 releases all.
// Result channel: rsp_valid is high for a single cycle per result, carrying
// rsp_slot_id, rsp_buffer_bytes, rsp_status and rsp_last; the receiver cannot stall, and
// rsp_last marks the final result of each input item.
// Steps: a request searches the idle list from its head for a buffer that
// fits, then closes the gap left by the hit; a miss instead takes the lowest
// free slot, or reports full when none is free. An end of frame ages the
// idle entries, releasing those that reach max_idle_frames, then moves the
// active list and the kept entries into the idle list; release all walks
// every slot and releases each valid one. Each result leaves through one
// output register; the done result shows in the same cycle in which busy is
// first low, and the next item can be taken at the edge that ends it. Reads
// of the slot size and age memory are registered, and the scan of that
// memory, one entry per step, sets the rate.
// Registers sit on an APB-style port: min_allocation at 0x0, max_idle_frames
// at 0x4; the user must write them only while busy is low (not enforced).
// Reset (synchronous) empties both lists and marks every slot free; no
// clearing pass is needed since all slot data is written before it is read.
module size_class_buffer_recycler
   import scbr_pkg::*;
#(
   parameter int SLOTS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_mode,
   input  logic [31:0] req_request_size,
   output logic        rsp_valid,
   output logic [3:0]  rsp_slot_id,
   output logic [32:0] rsp_buffer_bytes,
   output logic [2:0]  rsp_status,
   output logic        rsp_last,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CW = $clog2(SLOTS + 1);

   // configuration registers
   logic [31:0] min_alloc_ff;
   logic [7:0]  max_idle_ff;
   logic        csr_wr;
   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite;
   always_ff @(posedge clock) begin
      if (reset) begin
         min_alloc_ff <= MIN_ALLOC_RESET;
         max_idle_ff  <= MAX_IDLE_RESET;
      end else if (csr_wr && paddr[1:0] == 2'b00) begin
         if (paddr[2] == REG_MIN_ALLOC) min_alloc_ff <= pwdata;
         else max_idle_ff <= pwdata[7:0];
      end
   end
   always_comb begin
      if (paddr[2] == REG_MIN_ALLOC) prdata = min_alloc_ff;
      else prdata = {24'd0, max_idle_ff};
   end

   // slot memory: size and idle frame count; one write, one read port
   logic [40:0]   slot_mem [SLOTS];
   logic [IW-1:0] mem_raddr;
   logic [40:0]   mem_rdata_ff;
   logic          mem_we;
   logic [IW-1:0] mem_waddr;
   logic [40:0]   mem_wdata;
   always_ff @(posedge clock) begin
      if (mem_we) slot_mem[mem_waddr] <= mem_wdata;
      mem_rdata_ff <= slot_mem[mem_raddr];
   end

   // list memories (small, read combinationally, one write port each)
   logic [IW-1:0] idle_mem [SLOTS];
   logic [IW-1:0] act_mem  [SLOTS];
   logic [IW-1:0] keep_mem [SLOTS];

   logic [SLOTS-1:0] valid_ff, valid_in;
   logic [CW-1:0] idle_len_ff, idle_len_in, act_len_ff, act_len_in;
   logic [CW-1:0] idx_ff, idx_in, nkeep_ff, nkeep_in, n_ff, n_in;
   logic [31:0]   want_ff, want_in;
   state_type     state_ff, state_in;
   logic [IW-1:0] cur_ff, cur_in;

   // list write strobes
   logic          idle_we, act_we, keep_we;
   logic [IW-1:0] idle_wa, act_wa, keep_wa, idle_wd, act_wd, keep_wd;
   always_ff @(posedge clock) begin
      if (idle_we) idle_mem[idle_wa] <= idle_wd;
      if (act_we)  act_mem[act_wa]   <= act_wd;
      if (keep_we) keep_mem[keep_wa] <= keep_wd;
   end

   // output register
   logic          o_v_ff, o_v_in, o_last_ff, o_last_in;
   logic [3:0]    o_id_ff, o_id_in;
   logic [32:0]   o_by_ff, o_by_in;
   status_type    o_st_ff, o_st_in;

   // fit check and new size
   logic [32:0] have, want33, msz;
   logic        fit;
   logic [34:0] want5;
   logic [32:0] newsz;
   logic [7:0]  age;
   assign have   = mem_rdata_ff[32:0];
   assign want33 = {1'b0, want_ff};
   assign msz    = {1'b0, min_alloc_ff};
   assign fit    = (have == msz && want33 <= msz) ||
                   (have >= want33 && have < {want_ff, 1'b0});
   assign want5  = {3'd0, want_ff} + {1'b0, want_ff, 2'b00};
   assign newsz  = (want5[34:2] < msz) ? msz : want5[34:2];
   assign age    = (mem_rdata_ff[40:33] == 8'hFF) ? 8'hFF : mem_rdata_ff[40:33] + 8'd1;

   logic [IW-1:0] idx_i;
   assign idx_i  = idx_ff[IW-1:0];

   always_comb begin
      state_in = state_ff; idx_in = idx_ff; want_in = want_ff; cur_in = cur_ff;
      valid_in = valid_ff; idle_len_in = idle_len_ff; act_len_in = act_len_ff;
      nkeep_in = nkeep_ff; n_in = n_ff;
      o_v_in = 1'b0; o_last_in = 1'b0; o_id_in = '0; o_by_in = '0; o_st_in = ST_DONE;
      mem_raddr = idle_mem[idx_i]; mem_we = 1'b0; mem_waddr = cur_ff; mem_wdata = '0;
      idle_we = 1'b0; idle_wa = idx_i; idle_wd = '0;
      act_we = 1'b0; act_wa = act_len_ff[IW-1:0]; act_wd = cur_ff;
      keep_we = 1'b0; keep_wa = nkeep_ff[IW-1:0]; keep_wd = cur_ff;
      case (state_ff)
         S_IDLE: begin
            idx_in = '0;
            if (start) begin
               want_in = req_request_size;
               nkeep_in = '0; n_in = '0;
               case (mode_type'(req_mode))
                  MODE_REQ: state_in = S_REQ_RD;
                  MODE_EOF: state_in = S_EOF_RD;
                  MODE_RAL: state_in = S_RAL;
                  default:  state_in = S_DONE;
               endcase
            end
         end
         // read the idle entry at idx
         S_REQ_RD: begin
            mem_raddr = idle_mem[idx_i];
            cur_in = idle_mem[idx_i];
            if (idx_ff >= idle_len_ff) begin
               idx_in = '0; state_in = S_REQ_NEW;
            end else state_in = S_REQ_CHK;
         end
         S_REQ_CHK: begin
            if (fit) begin
               o_v_in = 1'b1; o_last_in = 1'b1; o_id_in = 4'(cur_ff);
               o_by_in = have; o_st_in = ST_HIT;
               mem_we = 1'b1; mem_wdata = {8'd0, have};
               act_we = (act_len_ff < CW'(SLOTS));
               act_len_in = act_we ? act_len_ff + 1'b1 : act_len_ff;
               state_in = S_REQ_SHIFT;
            end else begin
               idx_in = idx_ff + 1'b1; state_in = S_REQ_RD;
            end
         end
         // close the gap in the idle list
         S_REQ_SHIFT: begin
            if (idx_ff + 1'b1 < idle_len_ff) begin
               idle_we = 1'b1; idle_wd = idle_mem[IW'(idx_ff + 1'b1)];
               idx_in = idx_ff + 1'b1;
            end else begin
               idle_len_in = idle_len_ff - 1'b1; state_in = S_IDLE;
            end
         end
         // lowest free slot
         S_REQ_NEW: begin
            if (idx_ff >= CW'(SLOTS)) begin
               o_v_in = 1'b1; o_last_in = 1'b1; o_st_in = ST_FULL; state_in = S_IDLE;
            end else if (!valid_ff[idx_i]) begin
               valid_in[idx_i] = 1'b1;
               mem_we = 1'b1; mem_waddr = idx_i; mem_wdata = {8'd0, newsz};
               act_wd = idx_i;
               act_we = (act_len_ff < CW'(SLOTS));
               act_len_in = act_we ? act_len_ff + 1'b1 : act_len_ff;
               o_v_in = 1'b1; o_last_in = 1'b1; o_id_in = 4'(idx_i);
               o_by_in = newsz; o_st_in = ST_NEW; state_in = S_IDLE;
            end else idx_in = idx_ff + 1'b1;
         end
         // age idle buffers
         S_EOF_RD: begin
            mem_raddr = idle_mem[idx_i];
            cur_in = idle_mem[idx_i];
            if (idx_ff >= idle_len_ff) begin
               idx_in = '0; state_in = S_EOF_ACT;
            end else state_in = S_EOF_CHK;
         end
         S_EOF_CHK: begin
            mem_we = 1'b1; mem_wdata = {age, have};
            if (age >= max_idle_ff) begin
               valid_in[cur_ff] = 1'b0;
               o_v_in = 1'b1; o_id_in = 4'(cur_ff); o_by_in = have; o_st_in = ST_REL;
            end else begin
               keep_we = 1'b1; nkeep_in = nkeep_ff + 1'b1;
            end
            idx_in = idx_ff + 1'b1; state_in = S_EOF_RD;
         end
         // active list to the head of the idle list; counts are zero since acquisition
         S_EOF_ACT: begin
            if (idx_ff < act_len_ff) begin
               idle_we = 1'b1; idle_wa = n_ff[IW-1:0]; idle_wd = act_mem[idx_i];
               n_in = n_ff + 1'b1; idx_in = idx_ff + 1'b1;
            end else begin
               idx_in = '0; state_in = S_EOF_KEEP;
            end
         end
         S_EOF_KEEP: begin
            if (idx_ff < nkeep_ff && n_ff < CW'(SLOTS)) begin
               idle_we = 1'b1; idle_wa = n_ff[IW-1:0]; idle_wd = keep_mem[idx_i];
               n_in = n_ff + 1'b1; idx_in = idx_ff + 1'b1;
            end else begin
               idle_len_in = n_ff; act_len_in = '0; state_in = S_DONE;
            end
         end
         // release every valid slot, each after its size has been read
         S_RAL: begin
            mem_raddr = idx_i;
            cur_in = idx_i;
            if (idx_ff >= CW'(SLOTS)) begin
               idle_len_in = '0; act_len_in = '0; state_in = S_DONE;
            end else if (valid_ff[idx_i]) begin
               idx_in = idx_ff;
               if (n_ff == CW'(1)) begin
                  n_in = '0; valid_in[idx_i] = 1'b0;
                  o_v_in = 1'b1; o_id_in = 4'(idx_i); o_by_in = have; o_st_in = ST_REL;
                  idx_in = idx_ff + 1'b1;
               end else n_in = CW'(1);
            end else idx_in = idx_ff + 1'b1;
         end
         S_DONE: begin
            o_v_in = 1'b1; o_last_in = 1'b1; o_st_in = ST_DONE; state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; valid_ff <= '0; idle_len_ff <= '0; act_len_ff <= '0;
         o_v_ff <= 1'b0; idx_ff <= '0; nkeep_ff <= '0; n_ff <= '0;
      end else begin
         state_ff <= state_in; valid_ff <= valid_in; idle_len_ff <= idle_len_in;
         act_len_ff <= act_len_in; o_v_ff <= o_v_in; idx_ff <= idx_in;
         nkeep_ff <= nkeep_in; n_ff <= n_in;
      end
      want_ff <= want_in; cur_ff <= cur_in;
      o_last_ff <= o_last_in; o_id_ff <= o_id_in; o_by_ff <= o_by_in; o_st_ff <= o_st_in;
   end

   assign busy = (state_ff != S_IDLE);
   assign rsp_valid = o_v_ff;
   assign rsp_last = o_last_ff;
   assign rsp_slot_id = o_id_ff;
   assign rsp_buffer_bytes = o_by_ff;
   assign rsp_status = o_st_ff;

`ifndef SYNTH
   a_len: assert property (@(posedge clock) disable iff (reset)
      idle_len_ff <= CW'(SLOTS) && act_len_ff <= CW'(SLOTS))
      else $error("list length out of range");
   a_last: assert property (@(posedge clock) disable iff (reset)
      o_v_ff && o_last_ff |=> state_ff == S_IDLE || $past(state_ff) != S_DONE)
      else $error("done without return to idle");
   a_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted item did not raise busy");
`endif

endmodule
